// ===== design/bclp_pkg.sv =====
// Shared types and codes for the button click / long-press detector.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package bclp_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd3000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 2'd1;

  // Item opcodes; the fourth code is unused and changes nothing
  typedef enum logic [1:0] {
    OP_POLL       = 2'd0,
    OP_TAKE_CLICK = 2'd1,
    OP_TAKE_LONG  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              pin_level;
    logic [TIME_W-1:0] time_ms;
    logic              button_select;
  } item_t;

  typedef struct packed {
    logic event_taken;
    logic button_down;
    logic click_waiting;
    logic long_waiting;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_hold_ms;
  } cfg_t;

endpackage

// ===== design/bclp_cfg.sv =====
// Configuration registers: debounce time and long-hold time.
// Depends on bclp_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module bclp_cfg import bclp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  logic [CFG_W-1:0] debounce_r, debounce_nxt;
  logic [CFG_W-1:0] long_hold_r, long_hold_nxt;

  // Register decode; indexes beyond the list are dropped
  always_comb begin
    debounce_nxt  = debounce_r;
    long_hold_nxt = long_hold_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE:  debounce_nxt  = wr_data;
        CFG_LONG_HOLD: long_hold_nxt = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      long_hold_r <= LONG_HOLD_RST;
    end else begin
      debounce_r  <= debounce_nxt;
      long_hold_r <= long_hold_nxt;
    end
  end

  assign cfg.debounce_ms  = debounce_r;
  assign cfg.long_hold_ms = long_hold_r;

endmodule

// ===== design/bclp_core.sv =====
// Button state and event flags with the one-step update for each beat.
// Depends on bclp_pkg for item, result and configuration types.
`timescale 1ns / 1ps

module bclp_core import bclp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,      // apply item this cycle
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result     // result of item, valid with step
);

  logic              accepted_level_r, accepted_level_nxt;
  logic              deb_pressed_r, deb_pressed_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic [TIME_W-1:0] last_edge_r, last_edge_nxt;
  logic              long_fired_r, long_fired_nxt;
  logic              click_flag_r, click_flag_nxt;
  logic              long_flag_r, long_flag_nxt;

  logic              pressed;
  logic [TIME_W-1:0] held_time;
  logic [TIME_W-1:0] since_edge;
  logic              hold_reached;
  logic              debounce_ok;
  logic              taken;

  // Elapsed times wrap modulo the time width
  assign pressed      = ~item.pin_level;
  assign held_time    = item.time_ms - press_start_r;
  assign since_edge   = item.time_ms - last_edge_r;
  assign hold_reached = held_time >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_hold_ms};
  assign debounce_ok  = since_edge >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};

  // Next state for the item
  always_comb begin
    accepted_level_nxt = accepted_level_r;
    deb_pressed_nxt    = deb_pressed_r;
    press_start_nxt    = press_start_r;
    last_edge_nxt      = last_edge_r;
    long_fired_nxt     = long_fired_r;
    click_flag_nxt     = click_flag_r;
    long_flag_nxt      = long_flag_r;
    taken              = 1'b0;
    unique case (item.op)
      OP_POLL: begin
        // long press latches once and cancels a pending click
        if (pressed && deb_pressed_r && !long_fired_r && hold_reached) begin
          long_fired_nxt = 1'b1;
          long_flag_nxt  = 1'b1;
          click_flag_nxt = 1'b0;
        end
        // debounced level change
        if ((item.pin_level != accepted_level_r) && debounce_ok) begin
          accepted_level_nxt = item.pin_level;
          last_edge_nxt      = item.time_ms;
          if (pressed && !deb_pressed_r) begin
            press_start_nxt = item.time_ms;
            long_fired_nxt  = 1'b0;
          end else if (!pressed && deb_pressed_r) begin
            if (!long_fired_nxt) click_flag_nxt = 1'b1;
          end
          deb_pressed_nxt = pressed;
        end
      end
      OP_TAKE_CLICK: begin
        if (item.button_select && click_flag_r) begin
          click_flag_nxt = 1'b0;
          taken          = 1'b1;
        end
      end
      OP_TAKE_LONG: begin
        if (item.button_select && long_flag_r) begin
          long_flag_nxt = 1'b0;
          taken         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_level_r <= 1'b1;
      deb_pressed_r    <= 1'b0;
      press_start_r    <= '0;
      last_edge_r      <= '0;
      long_fired_r     <= 1'b0;
      click_flag_r     <= 1'b0;
      long_flag_r      <= 1'b0;
    end else if (step) begin
      accepted_level_r <= accepted_level_nxt;
      deb_pressed_r    <= deb_pressed_nxt;
      press_start_r    <= press_start_nxt;
      last_edge_r      <= last_edge_nxt;
      long_fired_r     <= long_fired_nxt;
      click_flag_r     <= click_flag_nxt;
      long_flag_r      <= long_flag_nxt;
    end
  end

  assign result.event_taken   = taken;
  assign result.button_down   = item.button_select & ~item.pin_level;
  assign result.click_waiting = click_flag_nxt;
  assign result.long_waiting  = long_flag_nxt;

endmodule

// ===== design/button_click_long_press_detector.sv =====
// Top level of the button click / long-press detector: input register,
// state update core, result register and configuration registers.
// Depends on bclp_pkg, bclp_cfg and bclp_core.
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   opcode, pin_level, time_ms, button_select
// out      output     out_valid / out_ready event_taken, button_down, click/long waiting
// cfg      input      cfg_valid / cfg_ready cfg_index (2 bits), cfg_wdata (16 bits)
//
// One beat per cycle sustained while out_ready stays high; an accepted beat passes
// through the input register, then the state update into the result register.
// The input register takes a new beat while a result waits to be taken, if it is empty.
// Stalls on out_ready back up through the input register to in_ready.
// Synchronous active-low reset: button released, flags clear, defaults loaded.
// cfg_ready is always high; writes are expected only while the block is idle.

module button_click_long_press_detector import bclp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  logic                 in_pin_level,
  input  logic [TIME_W-1:0]    in_time_ms,
  input  logic                 in_button_select,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_event_taken,
  output logic                 out_button_down,
  output logic                 out_click_waiting,
  output logic                 out_long_waiting,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  item_t   item_r;
  logic    in_valid_r, in_valid_nxt;
  result_t result_r, result_nxt;
  logic    out_valid_r, out_valid_nxt;
  cfg_t    cfg;
  logic    out_free;
  logic    fire;
  logic    in_take;

  assign cfg_ready = 1'b1;

  bclp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Pipeline control
  assign out_free = ~out_valid_r | out_ready;
  assign fire     = in_valid_r & out_free;
  assign in_ready = ~in_valid_r | out_free;
  assign in_take  = in_valid & in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)   in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (fire)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op            <= op_t'(in_opcode);
      item_r.pin_level     <= in_pin_level;
      item_r.time_ms       <= in_time_ms;
      item_r.button_select <= in_button_select;
    end
  end

  bclp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (result_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (fire) result_r <= result_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_taken   = result_r.event_taken;
  assign out_button_down   = result_r.button_down;
  assign out_click_waiting = result_r.click_waiting;
  assign out_long_waiting  = result_r.long_waiting;

  // A beat that moves forward always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("advanced beat did not reach the result register");

  // A poll never reports a taken event
  a_poll_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.op == OP_POLL) |-> !result_nxt.event_taken)
    else $error("poll reported a taken event");

  // A taken click leaves no click pending
  a_click_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.op == OP_TAKE_CLICK && result_nxt.event_taken)
      |-> !result_nxt.click_waiting)
    else $error("click still pending after take");

  // An empty input register never blocks the input channel
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled while input register empty");

endmodule
